@@ sv/text_console_writer_top_defines.svh @@
// Assertion macros for the assertion checker of the console writer.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Clocked property, switched off while reset is high.
`define TCW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/tcw_pkg.sv @@
package tcw_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 128;
   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = ADDR_W + 1;

   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_MOVE  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_BS = 8'h08;

   localparam logic [7:0] ATTR_RESET = 8'h0A;
   localparam logic [6:0] ROWS_RESET = 7'd25;
   localparam logic [7:0] COLS_RESET = 8'd80;

   localparam logic [1:0] CSR_ROWS   = 2'd0;
   localparam logic [1:0] CSR_COLS   = 2'd1;
   localparam logic [1:0] CSR_ATTR   = 2'd2;
   localparam logic [1:0] CSR_ENABLE = 2'd3;

   // Store write data sources
   localparam logic [1:0] WSRC_INIT  = 2'd0;
   localparam logic [1:0] WSRC_BLANK = 2'd1;
   localparam logic [1:0] WSRC_COPY  = 2'd2;
   localparam logic [1:0] WSRC_CELL  = 2'd3;

   typedef struct packed {
      logic       load_item;
      logic       decode;
      logic       idx_inc;
      logic       mem_wr;
      logic [1:0] wr_src;
      logic       rd_copy;
      logic       rd_cell;
      logic       addr_load;
      logic       advance;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic plan_scroll;
      logic plan_clear;
      logic cell_wr;
      logic init_last;
      logic sweep_last;
      logic copy_done;
   } status_type;

endpackage

@@ sv/text_console_writer_top.sv @@
// Text-mode console writer. Holds a 64 x 128 store of 16-bit cells (attribute in the high
// byte, character in the low byte) and a cursor; each request puts a character, moves the
// cursor, clears the screen or reads one cell, and returns one response with the cursor and
// any cell read. A plain transaction passes through the decode, address, store access and
// result load steps around the single-port store; the result load waits on a held response.
// A scroll walks the store one cell at a time, copying each line up onto the line above and
// then blanking the last line. A clear blanks rows*cols cells one at a time. After reset the
// block blanks all 8192 cells, one per cycle, and holds req_stall high until that is done;
// configuration writes are taken at any time but are meant for when the block is idle.
module text_console_writer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_char_code,
   input  logic [5:0] req_target_line,
   input  logic [6:0] req_target_column,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_cursor_line,
   output logic [7:0] rsp_cursor_column,
   output logic [7:0] rsp_cell_char,
   output logic [7:0] rsp_cell_attribute,
   output logic       rsp_scrolled,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type status;

   tcw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_char_code      (req_char_code),
      .req_target_line    (req_target_line),
      .req_target_column  (req_target_column),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_cursor_line    (rsp_cursor_line),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attribute (rsp_cell_attribute),
      .rsp_scrolled       (rsp_scrolled)
   );

endmodule

@@ sv/tcw_datapath.sv @@
module tcw_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tcw_pkg::cmd_type     cmd,
   output tcw_pkg::status_type  status,
   input  logic [1:0]           req_action,
   input  logic [7:0]           req_char_code,
   input  logic [5:0]           req_target_line,
   input  logic [6:0]           req_target_column,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   output logic [5:0]           rsp_cursor_line,
   output logic [7:0]           rsp_cursor_column,
   output logic [7:0]           rsp_cell_char,
   output logic [7:0]           rsp_cell_attribute,
   output logic                 rsp_scrolled
);

   function automatic logic [6:0] use_rows(input logic [6:0] v);
      logic [6:0] res;
      if (v < 7'd2) res = 7'd2;
      else if (v > 7'(tcw_pkg::MAX_ROWS)) res = 7'(tcw_pkg::MAX_ROWS);
      else res = v;
      return res;
   endfunction

   function automatic logic [7:0] use_cols(input logic [7:0] v);
      logic [7:0] res;
      if (v == 8'd0) res = 8'd1;
      else if (v > 8'(tcw_pkg::MAX_COLS)) res = 8'(tcw_pkg::MAX_COLS);
      else res = v;
      return res;
   endfunction

   function automatic logic [5:0] clamp_row(input logic [6:0] x, input logic [6:0] r);
      logic [6:0] rm1;
      rm1 = r - 7'd1;
      return (x >= r) ? rm1[5:0] : x[5:0];
   endfunction

   function automatic logic [7:0] clamp_col(input logic [7:0] x, input logic [7:0] c);
      return (x >= c) ? (c - 8'd1) : x;
   endfunction

   // configuration
   logic [6:0] rows_ff;
   logic [7:0] cols_ff;
   logic [7:0] attr_ff;
   logic       enable_ff;

   // latched transaction
   logic [1:0] action_ff;
   logic [7:0] char_ff;
   logic [5:0] tline_ff;
   logic [6:0] tcol_ff;

   logic [5:0] row_ff, row_in;
   logic [7:0] col_ff, col_in;

   logic scroll_ff, clear_ff, cell_wr_ff, blank_ff, read_ff, adv_ff;
   logic p_scroll, p_clear, p_wr, p_blank, p_read, p_adv;

   logic [tcw_pkg::CNT_W-1:0]  idx_ff, limit_ff, copy_end_ff;
   logic [tcw_pkg::CNT_W-1:0]  limit_in, src_idx, idx_next;
   logic [tcw_pkg::ADDR_W-1:0] addr_ff, addr_in, wr_addr, rd_addr;
   logic [15:0]                rdata_ff, wr_data;
   logic [15:0]                screen_mem [tcw_pkg::CELL_COUNT];

   logic [6:0]  r, rm1;
   logic [7:0]  c;
   logic [14:0] area;
   logic [5:0]  mul_row;
   logic [7:0]  mul_col;
   logic [13:0] cell_prod;
   logic [13:0] cell_sum;
   logic [5:0]  row1;
   logic [7:0]  col1;
   logic [6:0]  row_ext;

   assign r   = use_rows(rows_ff);
   assign c   = use_cols(cols_ff);
   assign rm1 = r - 7'd1;
   assign row_ext = {1'b0, row_ff};

   // cursor plan for the latched transaction
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      row1     = row_ff;
      col1     = col_ff;
      p_scroll = 1'b0;
      p_clear  = 1'b0;
      p_wr     = 1'b0;
      p_blank  = 1'b0;
      p_read   = 1'b0;
      p_adv    = 1'b0;
      if (action_ff == tcw_pkg::ACT_READ) begin
         p_read = ({1'b0, tline_ff} < r) && ({1'b0, tcol_ff} < c);
      end else if (enable_ff) begin
         unique case (action_ff)
            tcw_pkg::ACT_PUT: begin
               priority if (char_ff == tcw_pkg::CH_LF) begin
                  row1 = clamp_row(row_ext + 7'd1, r);
                  if ({1'b0, row1} >= rm1) begin
                     row_in   = row1 - 6'd1;
                     p_scroll = 1'b1;
                  end else begin
                     row_in = row1;
                  end
                  col_in = clamp_col(col_ff, c);
               end else if (char_ff == tcw_pkg::CH_CR) begin
                  row_in = clamp_row(row_ext, r);
                  col_in = 8'd0;
               end else if (char_ff == tcw_pkg::CH_BS) begin
                  if (col_ff != 8'd0) begin
                     row_in  = clamp_row(row_ext, r);
                     col_in  = clamp_col(col_ff - 8'd1, c);
                     p_wr    = 1'b1;
                     p_blank = 1'b1;
                  end else if (row_ff != 6'd0) begin
                     row_in  = clamp_row(row_ext - 7'd1, r);
                     col_in  = c - 8'd1;
                     p_wr    = 1'b1;
                     p_blank = 1'b1;
                  end
                  // backspace at the origin does nothing
               end else begin
                  // pending wrap goes to the start of the next line first
                  if (col_ff >= c) begin
                     row1 = clamp_row(row_ext + 7'd1, r);
                     col1 = 8'd0;
                  end
                  if ({1'b0, row1} >= rm1) begin
                     row_in   = clamp_row({1'b0, row1} - 7'd1, r);
                     p_scroll = 1'b1;
                  end else begin
                     row_in = row1;
                  end
                  col_in = col1;
                  p_wr   = 1'b1;
                  p_adv  = 1'b1;
               end
            end
            tcw_pkg::ACT_MOVE: begin
               row_in = clamp_row({1'b0, tline_ff}, r);
               col_in = clamp_col({1'b0, tcol_ff}, c);
            end
            tcw_pkg::ACT_CLEAR: begin
               row_in  = 6'd0;
               col_in  = 8'd0;
               p_clear = 1'b1;
            end
            tcw_pkg::ACT_READ: begin
            end
         endcase
      end
   end

   assign area     = 15'(r * c);
   assign limit_in = area[tcw_pkg::CNT_W-1:0];

   assign mul_row   = read_ff ? tline_ff : row_ff;
   assign mul_col   = read_ff ? {1'b0, tcol_ff} : col_ff;
   assign cell_prod = 14'(mul_row * c);
   assign cell_sum  = cell_prod + {6'd0, mul_col};
   assign addr_in   = cell_sum[tcw_pkg::ADDR_W-1:0];

   assign src_idx  = idx_ff + tcw_pkg::CNT_W'(c);
   assign idx_next = idx_ff + tcw_pkg::CNT_W'(1);

   assign wr_addr = (cmd.wr_src == tcw_pkg::WSRC_CELL) ? addr_ff
                                                       : idx_ff[tcw_pkg::ADDR_W-1:0];
   assign rd_addr = cmd.rd_copy ? src_idx[tcw_pkg::ADDR_W-1:0] : addr_ff;

   always_comb begin
      unique case (cmd.wr_src)
         tcw_pkg::WSRC_INIT:  wr_data = {tcw_pkg::ATTR_RESET, 8'h00};
         tcw_pkg::WSRC_BLANK: wr_data = {attr_ff, 8'h00};
         tcw_pkg::WSRC_COPY:  wr_data = rdata_ff;
         tcw_pkg::WSRC_CELL:  wr_data = {attr_ff, blank_ff ? 8'h00 : char_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         screen_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_copy || cmd.rd_cell) begin
         rdata_ff <= screen_mem[rd_addr];
      end
   end

   assign status.plan_scroll = p_scroll;
   assign status.plan_clear  = p_clear;
   assign status.cell_wr     = cell_wr_ff;
   assign status.init_last   = (idx_ff == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1));
   assign status.sweep_last  = (idx_next == limit_ff);
   assign status.copy_done   = (idx_ff == copy_end_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= tcw_pkg::ROWS_RESET;
         cols_ff    <= tcw_pkg::COLS_RESET;
         attr_ff    <= tcw_pkg::ATTR_RESET;
         enable_ff  <= 1'b1;
         action_ff  <= tcw_pkg::ACT_READ;
         row_ff     <= '0;
         col_ff     <= '0;
         idx_ff     <= '0;
         scroll_ff  <= 1'b0;
         clear_ff   <= 1'b0;
         cell_wr_ff <= 1'b0;
         blank_ff   <= 1'b0;
         read_ff    <= 1'b0;
         adv_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               tcw_pkg::CSR_ROWS:   rows_ff   <= csr_wdata[6:0];
               tcw_pkg::CSR_COLS:   cols_ff   <= csr_wdata;
               tcw_pkg::CSR_ATTR:   attr_ff   <= csr_wdata;
               tcw_pkg::CSR_ENABLE: enable_ff <= csr_wdata[0];
            endcase
         end
         if (cmd.load_item) begin
            action_ff <= req_action;
         end
         if (cmd.decode) begin
            row_ff     <= row_in;
            col_ff     <= col_in;
            scroll_ff  <= p_scroll;
            clear_ff   <= p_clear;
            cell_wr_ff <= p_wr;
            blank_ff   <= p_blank;
            read_ff    <= p_read;
            adv_ff     <= p_adv;
            idx_ff     <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_next;
         end
         if (cmd.advance && adv_ff) begin
            col_ff <= col_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         char_ff   <= req_char_code;
         tline_ff  <= req_target_line;
         tcol_ff   <= req_target_column;
      end
      if (cmd.decode) begin
         limit_ff    <= limit_in;
         copy_end_ff <= limit_in - tcw_pkg::CNT_W'(c);
      end
      if (cmd.addr_load) begin
         addr_ff <= addr_in;
      end
      if (cmd.out_load) begin
         rsp_cursor_line    <= row_ff;
         rsp_cursor_column  <= col_ff;
         rsp_cell_char      <= read_ff ? rdata_ff[7:0] : 8'h00;
         rsp_cell_attribute <= read_ff ? rdata_ff[15:8] : 8'h00;
         // clear needs no flag in the result; it only steers the sweep
         rsp_scrolled       <= scroll_ff && !clear_ff;
      end
   end

endmodule

@@ sv/tcw_controller.sv @@
module tcw_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  tcw_pkg::status_type  status,
   output tcw_pkg::cmd_type     cmd
);

   localparam logic [3:0] S_INIT      = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_DECODE    = 4'd2;
   localparam logic [3:0] S_SCR_RD    = 4'd3;
   localparam logic [3:0] S_SCR_WR    = 4'd4;
   localparam logic [3:0] S_SCR_BLANK = 4'd5;
   localparam logic [3:0] S_CLR       = 4'd6;
   localparam logic [3:0] S_ADDR      = 4'd7;
   localparam logic [3:0] S_CELL      = 4'd8;
   localparam logic [3:0] S_FINISH    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            // blank the whole store once after reset
            cmd.mem_wr  = 1'b1;
            cmd.wr_src  = tcw_pkg::WSRC_INIT;
            cmd.idx_inc = 1'b1;
            if (status.init_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            priority if (status.plan_scroll) state_in = S_SCR_RD;
            else if (status.plan_clear) state_in = S_CLR;
            else state_in = S_ADDR;
         end
         S_SCR_RD: begin
            if (status.copy_done) begin
               state_in = S_SCR_BLANK;
            end else begin
               cmd.rd_copy = 1'b1;
               state_in    = S_SCR_WR;
            end
         end
         S_SCR_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_src  = tcw_pkg::WSRC_COPY;
            cmd.idx_inc = 1'b1;
            state_in    = S_SCR_RD;
         end
         S_SCR_BLANK: begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_src  = tcw_pkg::WSRC_BLANK;
            cmd.idx_inc = 1'b1;
            if (status.sweep_last) state_in = S_ADDR;
         end
         S_CLR: begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_src  = tcw_pkg::WSRC_BLANK;
            cmd.idx_inc = 1'b1;
            if (status.sweep_last) state_in = S_ADDR;
         end
         S_ADDR: begin
            cmd.addr_load = 1'b1;
            state_in      = S_CELL;
         end
         S_CELL: begin
            cmd.mem_wr  = status.cell_wr;
            cmd.wr_src  = tcw_pkg::WSRC_CELL;
            cmd.rd_cell = 1'b1;
            cmd.advance = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/tcw_checker.sv @@
`include "text_console_writer_top_defines.svh"

module tcw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [5:0] rsp_cursor_line,
   input logic [7:0] rsp_cursor_column,
   input logic [7:0] rsp_cell_char,
   input logic [7:0] rsp_cell_attribute,
   input logic       rsp_scrolled
);

   // store blanking after reset keeps requests out
   `TCW_ASSERT_ALWAYS(a_init_stall, clock, reset |=> req_stall, "no stall after reset")

   // one transaction in flight at a time
   `TCW_ASSERT(a_one_at_a_time, clock, reset,
               (req_valid && !req_stall) |=> req_stall, "accepted back to back")

   // cursor column never passes the pending-wrap position
   `TCW_ASSERT(a_col_bound, clock, reset,
               rsp_valid |-> (rsp_cursor_column <= 8'd128), "cursor column out of range")

   `TCW_ASSERT(a_rsp_hold, clock, reset,
               (rsp_valid && rsp_stall) |=> rsp_valid, "response dropped while stalled")

   `TCW_ASSERT(a_rsp_stable, clock, reset,
               (rsp_valid && rsp_stall) |=> ($stable(rsp_cursor_line) &&
                  $stable(rsp_cursor_column) && $stable(rsp_cell_char) &&
                  $stable(rsp_cell_attribute) && $stable(rsp_scrolled)),
               "response changed while stalled")

endmodule

bind text_console_writer_top tcw_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_cursor_line    (rsp_cursor_line),
   .rsp_cursor_column  (rsp_cursor_column),
   .rsp_cell_char      (rsp_cell_char),
   .rsp_cell_attribute (rsp_cell_attribute),
   .rsp_scrolled       (rsp_scrolled)
);

@@ dv/text_console_writer_top_checker.sv @@
module text_console_writer_top_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_char_code,
   input  logic [5:0] req_target_line,
   input  logic [6:0] req_target_column,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [5:0] rsp_cursor_line,
   input  logic [7:0] rsp_cursor_column,
   input  logic [7:0] rsp_cell_char,
   input  logic [7:0] rsp_cell_attribute,
   input  logic       rsp_scrolled,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatch_total,
   output int         rsp_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [5:0] line;
      logic [7:0] column;
      logic [7:0] glyph;
      logic [7:0] attr;
      logic       scrolled;
   } console_rsp_type;

   // shadow of the screen store: attribute in the high byte, character in the low byte
   logic [15:0]     cells [tcw_pkg::CELL_COUNT];
   int unsigned     cur_line;
   int unsigned     cur_col;
   logic [6:0]      rows_reg;
   logic [7:0]      cols_reg;
   logic [7:0]      attr_reg;
   logic            enable_reg;
   console_rsp_type owed_q[$];

   function automatic int unsigned eff_rows();
      if (rows_reg < 2) return 2;
      if (rows_reg > tcw_pkg::MAX_ROWS) return tcw_pkg::MAX_ROWS;
      return 32'(rows_reg);
   endfunction

   function automatic int unsigned eff_cols();
      if (cols_reg < 1) return 1;
      if (cols_reg > tcw_pkg::MAX_COLS) return tcw_pkg::MAX_COLS;
      return 32'(cols_reg);
   endfunction

   function automatic void set_cursor(int unsigned line, int unsigned col);
      if (line >= eff_rows()) line = eff_rows() - 1;
      if (col >= eff_cols()) col = eff_cols() - 1;
      cur_line = line;
      cur_col  = col;
   endfunction

   function automatic void write_cell(int unsigned line, int unsigned col, logic [7:0] glyph);
      int unsigned idx;
      idx = line * eff_cols() + col;
      if (idx < tcw_pkg::CELL_COUNT) cells[idx] = {attr_reg, glyph};
   endfunction

   function automatic void scroll_screen();
      int unsigned nr, nc, dst;
      nr = eff_rows();
      nc = eff_cols();
      for (int unsigned ln = 0; ln + 1 < nr; ln++) begin
         for (int unsigned cl = 0; cl < nc; cl++) begin
            dst = ln * nc + cl;
            if (dst + nc < tcw_pkg::CELL_COUNT) cells[dst] = cells[dst + nc];
         end
      end
      for (int unsigned cl = 0; cl < nc; cl++) write_cell(nr - 1, cl, 8'h00);
   endfunction

   function automatic bit put_glyph(logic [7:0] glyph);
      int unsigned nr, nc;
      bit          sc;
      nr = eff_rows();
      nc = eff_cols();
      sc = 1'b0;
      case (glyph)
         tcw_pkg::CH_LF: begin
            set_cursor(cur_line + 1, cur_col);
            if (cur_line >= nr - 1) begin
               set_cursor(cur_line - 1, cur_col);
               scroll_screen();
               sc = 1'b1;
            end
            set_cursor(cur_line, cur_col);
         end
         tcw_pkg::CH_CR: set_cursor(cur_line, 0);
         tcw_pkg::CH_BS: begin
            // at the origin nothing happens
            if (cur_col > 0) begin
               set_cursor(cur_line, cur_col - 1);
               write_cell(cur_line, cur_col, 8'h00);
            end else if (cur_line > 0) begin
               set_cursor(cur_line - 1, nc - 1);
               write_cell(cur_line, cur_col, 8'h00);
            end
         end
         default: begin
            // pending wrap resolves before the byte lands
            if (cur_col >= nc) set_cursor(cur_line + 1, 0);
            if (cur_line >= nr - 1) begin
               set_cursor(cur_line - 1, cur_col);
               scroll_screen();
               sc = 1'b1;
            end
            write_cell(cur_line, cur_col, glyph);
            cur_col = cur_col + 1;
         end
      endcase
      return sc;
   endfunction

   function automatic console_rsp_type console_step(logic [1:0] act, logic [7:0] glyph,
                                                    logic [5:0] tl, logic [6:0] tc);
      console_rsp_type r;
      int unsigned     idx, n;
      r = '0;
      if (act == tcw_pkg::ACT_READ) begin
         if (tl < eff_rows() && tc < eff_cols()) begin
            idx = tl * eff_cols() + tc;
            if (idx < tcw_pkg::CELL_COUNT) {r.attr, r.glyph} = cells[idx];
         end
      end else if (enable_reg) begin
         case (act)
            tcw_pkg::ACT_PUT:  r.scrolled = put_glyph(glyph);
            tcw_pkg::ACT_MOVE: set_cursor(32'(tl), 32'(tc));
            default: begin
               n = eff_rows() * eff_cols();
               for (int unsigned i = 0; i < n && i < tcw_pkg::CELL_COUNT; i++)
                  cells[i] = {attr_reg, 8'h00};
               set_cursor(0, 0);
            end
         endcase
      end
      r.line   = cur_line[5:0];
      r.column = cur_col[7:0];
      return r;
   endfunction

   task automatic flag_failure(input string why, input console_rsp_type want,
                               input console_rsp_type seen);
      mismatch_total++;
      if (mismatch_total <= 10)
         $display("%0t %s: want %0d/%0d %h/%h %b, got %0d/%0d %h/%h %b",
                  $realtime, why, want.line, want.column, want.glyph, want.attr, want.scrolled,
                  seen.line, seen.column, seen.glyph, seen.attr, seen.scrolled);
   endtask

   always @(posedge clock) begin
      console_rsp_type want, seen;
      if (reset) begin
         for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) cells[i] = {tcw_pkg::ATTR_RESET, 8'h00};
         cur_line       = 0;
         cur_col        = 0;
         rows_reg       = tcw_pkg::ROWS_RESET;
         cols_reg       = tcw_pkg::COLS_RESET;
         attr_reg       = tcw_pkg::ATTR_RESET;
         enable_reg     = 1'b1;
         mismatch_total = 0;
         owed_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               tcw_pkg::CSR_ROWS:   rows_reg   = csr_wdata[6:0];
               tcw_pkg::CSR_COLS:   cols_reg   = csr_wdata;
               tcw_pkg::CSR_ATTR:   attr_reg   = csr_wdata;
               tcw_pkg::CSR_ENABLE: enable_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            owed_q.push_back(console_step(req_action, req_char_code, req_target_line,
                                          req_target_column));
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_cursor_line, rsp_cursor_column, rsp_cell_char, rsp_cell_attribute,
                     rsp_scrolled};
            if (owed_q.size() == 0) begin
               flag_failure("response with no transaction owed", '0, seen);
            end else begin
               want = owed_q.pop_front();
               if (want !== seen) flag_failure("response mismatch", want, seen);
            end
         end
      end
      rsp_owed <= owed_q.size();
   end

endmodule

@@ dv/text_console_writer_top_tb.sv @@
module text_console_writer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_action = tcw_pkg::ACT_READ;
   logic [7:0] req_char_code = 8'h00;
   logic [5:0] req_target_line = 6'd0;
   logic [6:0] req_target_column = 7'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [5:0] rsp_cursor_line;
   logic [7:0] rsp_cursor_column;
   logic [7:0] rsp_cell_char;
   logic [7:0] rsp_cell_attribute;
   logic       rsp_scrolled;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = tcw_pkg::CSR_ROWS;
   logic [7:0] csr_wdata = 8'h00;

   int          mismatch_total;
   int          rsp_owed;
   bit          send_idle = 1'b1;
   bit          rsp_idle = 1'b1;
   int          rsp_hold_cycles = 0;
   int unsigned scr_rows = tcw_pkg::ROWS_RESET;
   int unsigned scr_cols = tcw_pkg::COLS_RESET;

   always #2 clock = ~clock;

   text_console_writer_top dut (.*);

   text_console_writer_top_checker chk (.*);

   // one transaction: optional gap, then hold the payload until accepted
   task automatic issue_action(input logic [1:0] act, input logic [7:0] glyph,
                               input logic [5:0] line, input logic [6:0] col);
      int gap;
      gap = send_idle ? $urandom_range(17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_char_code     <= glyph;
      req_target_line   <= line;
      req_target_column <= col;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic issue_random();
      int unsigned pick, sel;
      logic [7:0]  g;
      logic [5:0]  l;
      logic [6:0]  c;
      pick = $urandom_range(99);
      g = 8'($urandom_range(255));
      l = 6'($urandom_range(63));
      c = 7'($urandom_range(127));
      if (pick < 55) begin
         sel = $urandom_range(99);
         if (sel < 25) g = tcw_pkg::CH_LF;
         else if (sel < 33) g = tcw_pkg::CH_CR;
         else if (sel < 45) g = tcw_pkg::CH_BS;
         issue_action(tcw_pkg::ACT_PUT, g, l, c);
      end else if (pick < 70) begin
         if ($urandom_range(1)) begin
            l = 6'($urandom_range(scr_rows - 1));
            c = 7'($urandom_range(scr_cols - 1));
         end
         issue_action(tcw_pkg::ACT_MOVE, g, l, c);
      end else if (pick < 74) begin
         issue_action(tcw_pkg::ACT_CLEAR, g, l, c);
      end else begin
         if ($urandom_range(4) != 0) begin
            l = 6'($urandom_range(scr_rows - 1));
            c = 7'($urandom_range(scr_cols - 1));
         end
         issue_action(tcw_pkg::ACT_READ, g, l, c);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_screen(input logic [6:0] rows, input logic [7:0] cols,
                                 input logic [7:0] attr, input logic en);
      wait_idle();
      scr_rows = (rows < 2) ? 2 : ((rows > tcw_pkg::MAX_ROWS) ? tcw_pkg::MAX_ROWS : rows);
      scr_cols = (cols < 1) ? 1 : ((cols > tcw_pkg::MAX_COLS) ? tcw_pkg::MAX_COLS : cols);
      csr_wr_en <= 1'b1;
      csr_index <= tcw_pkg::CSR_ROWS;
      csr_wdata <= {1'b0, rows};
      @(posedge clock);
      csr_index <= tcw_pkg::CSR_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= tcw_pkg::CSR_ATTR;
      csr_wdata <= attr;
      @(posedge clock);
      csr_index <= tcw_pkg::CSR_ENABLE;
      csr_wdata <= {7'd0, en};
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : rsp_side
      int gap;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         gap = rsp_idle ? $urandom_range(17) : 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("text_console_writer_top_tb: errors");
      $finish;
   end

   initial begin : stimulus
      int count;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // power-on contents and register defaults
      issue_action(tcw_pkg::ACT_READ, 8'h00, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_MOVE, 8'h00, 6'd63, 7'd127);
      issue_action(tcw_pkg::ACT_CLEAR, 8'h00, 6'd0, 7'd0);

      // tiny 3 x 4 screen: wrap, control bytes, scrolling, clamping
      program_screen(7'd3, 8'd4, 8'h5A, 1'b1);
      issue_action(tcw_pkg::ACT_CLEAR, 8'h00, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_PUT, 8'h00, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_PUT, 8'hFF, 6'd63, 7'd127);
      issue_action(tcw_pkg::ACT_PUT, 8'h61, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_PUT, 8'h62, 6'd0, 7'd0);          // pending wrap
      issue_action(tcw_pkg::ACT_PUT, tcw_pkg::CH_LF, 6'd0, 7'd0); // line feed out of pending wrap
      issue_action(tcw_pkg::ACT_PUT, tcw_pkg::CH_CR, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_PUT, tcw_pkg::CH_BS, 6'd0, 7'd0); // back onto previous line
      issue_action(tcw_pkg::ACT_PUT, 8'h63, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_PUT, tcw_pkg::CH_BS, 6'd0, 7'd0); // backspace out of pending wrap
      issue_action(tcw_pkg::ACT_MOVE, 8'h00, 6'd1, 7'd3);
      issue_action(tcw_pkg::ACT_PUT, 8'h64, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_PUT, 8'h65, 6'd0, 7'd0);          // wrap into bottom line scrolls
      issue_action(tcw_pkg::ACT_PUT, tcw_pkg::CH_LF, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_MOVE, 8'h00, 6'd63, 7'd127);
      issue_action(tcw_pkg::ACT_PUT, tcw_pkg::CH_LF, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_MOVE, 8'h00, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_PUT, tcw_pkg::CH_BS, 6'd0, 7'd0); // origin: no effect
      issue_action(tcw_pkg::ACT_READ, 8'h00, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_READ, 8'h00, 6'd63, 7'd127);

      // disabled: writes ignored, reads still served
      program_screen(7'd3, 8'd4, 8'hA5, 1'b0);
      issue_action(tcw_pkg::ACT_PUT, 8'h41, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_MOVE, 8'h00, 6'd1, 7'd1);
      issue_action(tcw_pkg::ACT_CLEAR, 8'h00, 6'd0, 7'd0);
      issue_action(tcw_pkg::ACT_READ, 8'h00, 6'd0, 7'd1);

      for (int p = 0; p < 14; p++) begin
         case (p)
            0: begin
               program_screen(7'd0, 8'd0, 8'h00, 1'b1);
               count = 30;
            end
            1: begin
               program_screen(7'd127, 8'd255, 8'hFF, 1'b1);
               count = 12;
            end
            2: begin
               program_screen(7'd64, 8'd128, 8'($urandom_range(255)), 1'b1);
               count = 12;
            end
            3: begin
               program_screen(7'd2, 8'd128, 8'($urandom_range(255)), 1'b1);
               count = 30;
            end
            4: begin
               program_screen(7'd64, 8'd1, 8'($urandom_range(255)), 1'b1);
               count = 30;
            end
            5: begin
               program_screen(7'($urandom_range(8)), 8'($urandom_range(16)),
                              8'($urandom_range(255)), 1'b0);
               count = 15;
            end
            default: begin
               program_screen(7'($urandom_range(8)), 8'($urandom_range(16)),
                              8'($urandom_range(255)), 1'b1);
               count = 38;
            end
         endcase
         send_idle = (p % 3 != 1);
         rsp_idle  = (p % 4 != 2);
         if (p == 9) begin
            // back-to-back requests against a long response hold-off
            send_idle       = 1'b0;
            rsp_hold_cycles = 300;
         end
         if (scr_rows == tcw_pkg::MAX_ROWS && scr_cols == tcw_pkg::MAX_COLS) begin
            issue_action(tcw_pkg::ACT_MOVE, 8'h00, 6'd62, 7'd127);
            issue_action(tcw_pkg::ACT_PUT, 8'h5A, 6'd0, 7'd0);
            issue_action(tcw_pkg::ACT_PUT, 8'h59, 6'd0, 7'd0);
         end
         repeat (count) issue_random();
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatch_total == 0)
         $display("text_console_writer_top_tb: clean");
      else
         $display("text_console_writer_top_tb: errors");
      $finish;
   end

endmodule
